/* design/wcbf_pkg.sv */
// shared types and constants of the webm cluster and block framer
`timescale 1ns / 1ps

package wcbf_pkg;

    // timestamp bits in use and the timecode bytes they can need
    localparam int TIME_BITS = 48;
    localparam int TC_BYTES  = (TIME_BITS + 7) / 8;
    localparam int TC_W      = TC_BYTES * 8;
    localparam int TCL_W     = $clog2(TC_BYTES + 1);

    // field widths
    localparam int TIME_W = 48;
    localparam int LEN_W  = 32;
    localparam int CFG_W  = 15;
    localparam int SZ_W   = 40;
    localparam int SDATA_W = 96;

    // input kind carried on tuser
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // register indexes
    localparam logic CFG_SPAN = 1'b0;
    localparam logic CFG_ROLL = 1'b1;

    localparam logic [CFG_W-1:0] SPAN_RESET = 15'd5000;
    localparam logic [CFG_W-1:0] ROLL_RESET = 15'd500;

    // element ids and fixed bytes
    localparam logic [31:0] CLUSTER_ID  = 32'h1F43B675;
    localparam logic [7:0]  SBLOCK_ID   = 8'hA3;
    localparam logic [7:0]  TIMECODE_ID = 8'hE7;
    localparam logic [7:0]  USZ_LEAD    = 8'h01;
    localparam logic [7:0]  USZ_FILL    = 8'hFF;
    localparam logic [7:0]  TC_LEN_MARK = 8'h80;
    localparam logic [7:0]  TRACK_VIDEO = 8'h81;
    localparam logic [7:0]  TRACK_AUDIO = 8'h82;
    localparam logic [7:0]  KEY_FLAG    = 8'h80;
    localparam logic [7:0]  NO_FLAG     = 8'h00;
    localparam logic [7:0]  VINT_MARK   = 8'h80;

    // vint size limits, one byte more above each
    localparam logic [32:0] VINT1_LIM = 33'h7F;
    localparam logic [32:0] VINT2_LIM = 33'h3FFF;
    localparam logic [32:0] VINT3_LIM = 33'h1FFFFF;
    localparam logic [32:0] VINT4_LIM = 33'h0FFFFFFF;
    localparam logic [32:0] BLOCK_EXTRA = 33'd4;

    // relative time saturation
    localparam logic [15:0] REL_MAX = 16'h7FFF;
    localparam logic [15:0] REL_MIN = 16'h8000;

    // command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one classified item between front and back
    typedef struct packed {
        logic              is_pay;
        logic [7:0]        pay_byte;
        logic              open;
        logic [TC_W-1:0]   tc;
        logic [TCL_W-1:0]  tc_len;
        logic [SZ_W-1:0]   sz;
        logic [2:0]        sz_len;
        logic              audio;
        logic              key;
        logic [15:0]       rel;
    } cmd_t;

    // queue status seen by the top level
    typedef struct packed {
        logic              full;
        logic              head_valid;
        logic [QCNT_W-1:0] count;
    } qstat_t;

endpackage

/* design/wcbf_front.sv */
// front end: accepts items, decides cluster opening, builds header commands
`timescale 1ns / 1ps

module wcbf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [wcbf_pkg::SDATA_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [wcbf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        q_full,
    output logic                        push,
    output wcbf_pkg::cmd_t              cmd
);
    import wcbf_pkg::*;

    logic [CFG_W-1:0]     span_reg;
    logic [CFG_W-1:0]     roll_reg;
    logic                 open_reg;
    logic [TIME_BITS-1:0] start_reg;

    logic                 audio;
    logic                 key;
    logic [TIME_BITS-1:0] t;
    logic [LEN_W-1:0]     len;
    logic [7:0]           pbyte;
    logic                 accept;
    logic                 drop;
    logic [TIME_BITS:0]   diff;
    logic                 nonneg;
    logic                 ge_roll;
    logic                 ge_span;
    logic                 roll;
    logic [15:0]          rel;
    logic [TCL_W-1:0]     nb;
    logic [32:0]          sz;
    logic [2:0]           vk;

    // field unpacking
    assign audio = s_tdata[0];
    assign key   = s_tdata[1] & ~s_tdata[0];
    assign t     = s_tdata[2 +: TIME_BITS];
    assign len   = s_tdata[50 +: LEN_W];
    assign pbyte = s_tdata[82 +: 8];

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;
    assign drop     = (s_tuser == OP_FRAME) && (len == '0);
    assign push     = accept & ~drop;

    // elapsed time against the open cluster
    assign diff    = {1'b0, t} - {1'b0, start_reg};
    assign nonneg  = ~diff[TIME_BITS];
    assign ge_roll = nonneg && ((|diff[TIME_BITS-1:CFG_W]) || (diff[CFG_W-1:0] >= roll_reg));
    assign ge_span = nonneg && ((|diff[TIME_BITS-1:CFG_W]) || (diff[CFG_W-1:0] >= span_reg));
    assign roll    = ~open_reg || (~audio && ((key && ge_roll) || ge_span));

    // relative time, saturated to 16 bits signed
    always_comb
    begin
        if (roll)
            rel = '0;
        else if (nonneg)
            rel = (|diff[TIME_BITS-1:15]) ? REL_MAX : {1'b0, diff[14:0]};
        else
            rel = (&diff[TIME_BITS:15]) ? diff[15:0] : REL_MIN;
    end

    // fewest timecode bytes
    always_comb
    begin
        nb = TCL_W'(1);
        for (int i = 1; i < TC_BYTES; i++)
        begin
            if (TC_W'(t) >> (8 * i) != '0)
                nb = TCL_W'(i + 1);
        end
    end

    // block size vint length
    assign sz = {1'b0, len} + BLOCK_EXTRA;
    always_comb
    begin
        if (sz < VINT1_LIM)
            vk = 3'd1;
        else if (sz < VINT2_LIM)
            vk = 3'd2;
        else if (sz < VINT3_LIM)
            vk = 3'd3;
        else if (sz < VINT4_LIM)
            vk = 3'd4;
        else
            vk = 3'd5;
    end

    // command toward the back end
    always_comb
    begin
        cmd.is_pay   = (s_tuser == OP_BYTE);
        cmd.pay_byte = pbyte;
        cmd.open     = roll;
        cmd.tc       = TC_W'(t);
        cmd.tc_len   = nb;
        cmd.sz       = SZ_W'(sz);
        cmd.sz_len   = vk;
        cmd.audio    = audio;
        cmd.key      = key;
        cmd.rel      = rel;
    end

    // cluster state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (push && (s_tuser == OP_FRAME) && roll)
        begin
            open_reg  <= 1'b1;
            start_reg <= t;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= SPAN_RESET;
            roll_reg <= ROLL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SPAN)
                span_reg <= cfg_data;
            else
                roll_reg <= cfg_data;
        end
    end

endmodule

/* design/wcbf_queue.sv */
// short command queue between front and back ends
`timescale 1ns / 1ps

module wcbf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wcbf_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output wcbf_pkg::cmd_t   head,
    output wcbf_pkg::qstat_t stat
);
    import wcbf_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head            = mem_reg[rd_reg];
    assign stat.full       = (count_reg == QCNT_W'(QDEPTH));
    assign stat.head_valid = (count_reg != '0);
    assign stat.count      = count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

/* design/wcbf_back.sv */
// back end: serializes queued commands into output bytes
`timescale 1ns / 1ps

module wcbf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  wcbf_pkg::cmd_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import wcbf_pkg::*;

    typedef enum logic [12:0] {
        ST_START = 13'b0000000000001,
        ST_PAY   = 13'b0000000000010,
        ST_CID   = 13'b0000000000100,
        ST_USZ   = 13'b0000000001000,
        ST_TCID  = 13'b0000000010000,
        ST_TCLEN = 13'b0000000100000,
        ST_TC    = 13'b0000001000000,
        ST_SBID  = 13'b0000010000000,
        ST_VINT  = 13'b0000100000000,
        ST_TRACK = 13'b0001000000000,
        ST_RELHI = 13'b0010000000000,
        ST_RELLO = 13'b0100000000000,
        ST_FLAGS = 13'b1000000000000
    } bstate_t;

    bstate_t    state_reg;
    bstate_t    state_next;
    bstate_t    cur;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       mvalid_reg;
    logic [7:0] mdata_reg;
    logic       mlast_reg;

    logic [7:0] obyte;
    logic       olast;
    logic       go;
    logic [3:0] tc_pos;
    logic [3:0] tc_end;
    logic [2:0] sz_pos;
    logic [7:0] tc_byte;
    logic [7:0] sz_byte;

    assign go  = head_valid & (~mvalid_reg | m_tready);
    assign pop = go & olast;

    // first byte of a command comes from the queue head
    always_comb
    begin
        cur = state_reg;
        if (state_reg == ST_START)
            cur = head.is_pay ? ST_PAY : (head.open ? ST_CID : ST_SBID);
    end

    // byte selection for timecode and block size
    assign tc_end = 4'(head.tc_len) - 4'd1;
    assign tc_pos = tc_end - {1'b0, cnt_reg};
    assign sz_pos = head.sz_len - 3'd1 - cnt_reg;
    always_comb
    begin
        tc_byte = '0;
        for (int i = 0; i < TC_BYTES; i++)
        begin
            if (tc_pos == 4'(i))
                tc_byte = head.tc[8 * i +: 8];
        end
        sz_byte = '0;
        for (int i = 0; i < SZ_W / 8; i++)
        begin
            if (sz_pos == 3'(i))
                sz_byte = head.sz[8 * i +: 8];
        end
    end

    // byte sequencer
    always_comb
    begin
        obyte      = '0;
        olast      = 1'b0;
        state_next = cur;
        cnt_next   = cnt_reg + 3'd1;
        unique case (cur)
            ST_PAY:
            begin
                obyte      = head.pay_byte;
                olast      = 1'b1;
                state_next = ST_START;
                cnt_next   = '0;
            end
            ST_CID:
            begin
                obyte = 8'(CLUSTER_ID >> {~cnt_reg[1:0], 3'b000});
                if (cnt_reg == 3'd3)
                begin
                    state_next = ST_USZ;
                    cnt_next   = '0;
                end
            end
            ST_USZ:
            begin
                obyte = (cnt_reg == 3'd0) ? USZ_LEAD : USZ_FILL;
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_TCID;
                    cnt_next   = '0;
                end
            end
            ST_TCID:
            begin
                obyte      = TIMECODE_ID;
                state_next = ST_TCLEN;
                cnt_next   = '0;
            end
            ST_TCLEN:
            begin
                obyte      = TC_LEN_MARK | 8'(head.tc_len);
                state_next = ST_TC;
                cnt_next   = '0;
            end
            ST_TC:
            begin
                obyte = tc_byte;
                if ({1'b0, cnt_reg} == tc_end)
                begin
                    state_next = ST_SBID;
                    cnt_next   = '0;
                end
            end
            ST_SBID:
            begin
                obyte      = SBLOCK_ID;
                state_next = ST_VINT;
                cnt_next   = '0;
            end
            ST_VINT:
            begin
                obyte = sz_byte;
                if (cnt_reg == 3'd0)
                    obyte = sz_byte | (VINT_MARK >> (head.sz_len - 3'd1));
                if (cnt_reg == head.sz_len - 3'd1)
                begin
                    state_next = ST_TRACK;
                    cnt_next   = '0;
                end
            end
            ST_TRACK:
            begin
                obyte      = head.audio ? TRACK_AUDIO : TRACK_VIDEO;
                state_next = ST_RELHI;
                cnt_next   = '0;
            end
            ST_RELHI:
            begin
                obyte      = head.rel[15:8];
                state_next = ST_RELLO;
                cnt_next   = '0;
            end
            ST_RELLO:
            begin
                obyte      = head.rel[7:0];
                state_next = ST_FLAGS;
                cnt_next   = '0;
            end
            ST_FLAGS:
            begin
                obyte      = head.key ? KEY_FLAG : NO_FLAG;
                olast      = 1'b1;
                state_next = ST_START;
                cnt_next   = '0;
            end
            default:
            begin
                state_next = ST_START;
                cnt_next   = '0;
            end
        endcase
    end

    // sequencer position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            cnt_reg   <= '0;
        end
        else if (go)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= 1'b0;
        else if (go)
            mvalid_reg <= 1'b1;
        else if (m_tready)
            mvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mdata_reg <= obyte;
            mlast_reg <= olast;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

/* design/webm_cluster_block_framer.sv */
// top level of the webm cluster and simpleblock framer
//
//  port group    dir  payload
//  s_t*          in   tuser: op; tdata: is_audio, key_frame, time_ms, frame_length,
//                     payload_byte, zero pad
//  m_t*          out  tdata: out_byte; tlast: last_of_run
//  cfg_*         in   index 0 cluster_span_ms, index 1 key_roll_ms
//
// an input transfer is taken whenever the four-entry command queue has room
// a payload byte goes from the queue head through the output byte register;
// a frame header is 6 to 10 output bytes, plus 15 to 20 when a cluster opens
// the output byte register sets the sustained rate: one output transfer per cycle
// while m_tready is high and the queue holds a command; reset clears the cluster state,
// the queue and the output register; config returns to span 5000 ms and key roll 500 ms
`timescale 1ns / 1ps

module webm_cluster_block_framer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // is_audio, key_frame, time_ms[47:0], frame_length[31:0], payload_byte[7:0], pad
    input  logic [wcbf_pkg::SDATA_W-1:0] s_tdata,
    // op
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_byte
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [wcbf_pkg::CFG_W-1:0]   cfg_data
);
    import wcbf_pkg::*;

    logic   push;
    logic   pop;
    cmd_t   push_cmd;
    cmd_t   head;
    qstat_t qstat;

    // classify and build commands
    wcbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (qstat.full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // decoupling queue
    wcbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    // byte serializer
    wcbf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (qstat.head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // queue is never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("command queue written while full");

    // back end only retires a command that is present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qstat.head_valid)
        else $error("command popped from empty queue");

    // fill count stays within depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    // each retired command ends with a last byte on the output register
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid && m_tlast))
        else $error("retired command did not end in a last byte");

endmodule
